// ===== rtl/core/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock with entry log.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

    // Input item kinds.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    // Key codes.
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_STAR      = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;

    // Result kinds.
    localparam logic [3:0] KIND_TIME        = 4'd0;
    localparam logic [3:0] KIND_DIGIT       = 4'd1;
    localparam logic [3:0] KIND_ENROL_START = 4'd2;
    localparam logic [3:0] KIND_ENROLLED    = 4'd3;
    localparam logic [3:0] KIND_TABLE_FULL  = 4'd4;
    localparam logic [3:0] KIND_GRANTED     = 4'd5;
    localparam logic [3:0] KIND_DENIED      = 4'd6;
    localparam logic [3:0] KIND_LOG_ENTRY   = 4'd7;
    localparam logic [3:0] KIND_LOG_EMPTY   = 4'd8;

    // Time-of-day limits.
    localparam logic [4:0] LAST_HOUR   = 5'd23;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [5:0] LAST_SECOND = 6'd59;

    // Most results one hash press may replay.
    localparam int unsigned MAX_RESULTS = 32;

    // Codes loaded into the table after reset.
    localparam int unsigned PRESET_NUM = 6;
    localparam logic [15:0] PRESET_CODES [PRESET_NUM] = '{
        16'h0000, 16'h1234, 16'h4321, 16'h1111, 16'h1380, 16'h1382
    };

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_tod;

    typedef struct packed {
        t_tod        tod;
        logic [15:0] code;
    } t_log_entry;

    typedef struct packed {
        logic        append;
        logic        scan;
        logic [15:0] code;
    } t_tbl_req;

    typedef struct packed {
        logic busy;
        logic full;
        logic done;
        logic match;
    } t_tbl_rsp;

    typedef struct packed {
        logic       append;
        t_log_entry entry;
    } t_log_req;

endpackage

`default_nettype wire

// ===== rtl/core/kcl_if.sv =====
// ----------------------------------------------------------------------------
// kcl_if
// Valid/ready channels for key and tick items and for lock results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink (input valid, input func, input key, output ready);
endinterface

interface kcl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [15:0] code_digits;
    logic        held;
    logic        log_full;
    logic        last;

    modport source (output valid, output kind, output hours, output minutes,
                    output seconds, output code_digits, output held,
                    output log_full, output last, input ready);
    modport sink (input valid, input kind, input hours, input minutes,
                  input seconds, input code_digits, input held,
                  input log_full, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/keypad_code_lock_with_log_core.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_with_log_core
// Ticks, star, digits: one result each, held in S_EMIT until the output register is free.
// A finished code outside enrol mode scans the table in S_SCAN before its result.
// Hash replays the log one entry at a time, through S_LOGRD for the registered log read.
// After reset the table loads its preset codes; no item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock_with_log_core import kcl_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    parameter int LOG_DEPTH   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcl_in_if.sink    i_in,
    kcl_out_if.source o_out
);

    localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int LCW = $clog2(LOG_DEPTH + 1);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_LOGRD  = 3'd4;
    localparam logic [2:0] S_LOGOUT = 3'd5;

    logic [2:0]     r_state,    n_state;
    t_tod           r_time,     n_time;
    logic [1:0]     r_dig,      n_dig;
    logic [11:0]    r_entry,    n_entry;
    logic           r_enrol,    n_enrol;
    logic [3:0]     r_res_kind, n_res_kind;
    logic [15:0]    r_res_code, n_res_code;
    logic           r_res_full, n_res_full;
    logic [LCW-1:0] r_idx,      n_idx;

    logic           r_out_valid, n_out_valid;
    logic [3:0]     r_out_kind,  n_out_kind;
    t_tod           r_out_tod,   n_out_tod;
    logic [15:0]    r_out_code,  n_out_code;
    logic           r_out_held,  n_out_held;
    logic           r_out_full,  n_out_full;
    logic           r_out_last,  n_out_last;

    t_tbl_req       tbl_req;
    t_tbl_rsp       tbl_rsp;
    t_log_req       log_req;
    t_log_entry     log_rd;
    logic           log_full;
    logic [LCW-1:0] replay_n;
    logic           out_free;
    logic [15:0]    code_new;

    kcl_code_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    kcl_event_log #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (log_req),
        .i_rd_addr  (r_idx[LAW-1:0]),
        .o_rd_data  (log_rd),
        .o_full     (log_full),
        .o_replay_n (replay_n)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign code_new   = {r_entry, i_in.key};
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_dig       = r_dig;
        n_entry     = r_entry;
        n_enrol     = r_enrol;
        n_res_kind  = r_res_kind;
        n_res_code  = r_res_code;
        n_res_full  = r_res_full;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_tod   = r_out_tod;
        n_out_code  = r_out_code;
        n_out_held  = r_out_held;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;
        tbl_req     = '0;
        log_req     = '0;
        log_req.entry.tod  = r_time;
        log_req.entry.code = r_res_code;

        unique case (r_state)
            S_INIT: begin
                if (!tbl_rsp.busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res_code = '0;
                    n_res_full = 1'b0;
                    if (i_in.func == FUNC_TICK) begin
                        // Carry through seconds, minutes and hours.
                        if (r_time.seconds != LAST_SECOND) begin
                            n_time.seconds = r_time.seconds + 6'd1;
                        end else begin
                            n_time.seconds = '0;
                            if (r_time.minutes != LAST_MINUTE) begin
                                n_time.minutes = r_time.minutes + 6'd1;
                            end else begin
                                n_time.minutes = '0;
                                if (r_time.hours != LAST_HOUR) begin
                                    n_time.hours = r_time.hours + 5'd1;
                                end else begin
                                    n_time.hours = '0;
                                end
                            end
                        end
                        n_res_kind = KIND_TIME;
                        n_state    = S_EMIT;
                    end else if (i_in.key == KEY_STAR) begin
                        n_enrol    = 1'b1;
                        n_dig      = '0;
                        n_entry    = '0;
                        n_res_kind = KIND_ENROL_START;
                        n_state    = S_EMIT;
                    end else if (i_in.key == KEY_HASH) begin
                        n_enrol = 1'b0;
                        n_idx   = '0;
                        if (replay_n == '0) begin
                            n_res_kind = KIND_LOG_EMPTY;
                            n_state    = S_EMIT;
                        end else begin
                            n_state = S_LOGRD;
                        end
                    end else if (i_in.key <= KEY_DIGIT_MAX) begin
                        n_res_code = code_new;
                        if (r_dig != 2'd3) begin
                            n_entry    = code_new[11:0];
                            n_dig      = r_dig + 2'd1;
                            n_res_kind = KIND_DIGIT;
                            n_state    = S_EMIT;
                        end else begin
                            n_entry = '0;
                            n_dig   = '0;
                            if (r_enrol) begin
                                if (!tbl_rsp.full) begin
                                    tbl_req.append = 1'b1;
                                    tbl_req.code   = code_new;
                                    n_enrol        = 1'b0;
                                    n_res_kind     = KIND_ENROLLED;
                                end else begin
                                    n_res_kind = KIND_TABLE_FULL;
                                end
                                n_state = S_EMIT;
                            end else begin
                                tbl_req.scan = 1'b1;
                                tbl_req.code = code_new;
                                n_state      = S_SCAN;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (tbl_rsp.done) begin
                    if (tbl_rsp.match) begin
                        log_req.append = !log_full;
                        n_res_full     = log_full;
                        n_res_kind     = KIND_GRANTED;
                    end else begin
                        n_res_kind = KIND_DENIED;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_tod   = r_time;
                    n_out_code  = r_res_code;
                    n_out_held  = r_enrol;
                    n_out_full  = r_res_full;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LOGRD: begin
                // The log read of r_idx lands in the next cycle.
                n_state = S_LOGOUT;
            end
            S_LOGOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_LOG_ENTRY;
                    n_out_tod   = log_rd.tod;
                    n_out_code  = log_rd.code;
                    n_out_held  = r_enrol;
                    n_out_full  = 1'b0;
                    n_out_last  = ((r_idx + LCW'(1)) == replay_n);
                    if ((r_idx + LCW'(1)) == replay_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + LCW'(1);
                        n_state = S_LOGRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_time      <= '0;
            r_dig       <= '0;
            r_entry     <= '0;
            r_enrol     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_dig       <= n_dig;
            r_entry     <= n_entry;
            r_enrol     <= n_enrol;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_kind <= n_res_kind;
        r_res_code <= n_res_code;
        r_res_full <= n_res_full;
        r_out_kind <= n_out_kind;
        r_out_tod  <= n_out_tod;
        r_out_code <= n_out_code;
        r_out_held <= n_out_held;
        r_out_full <= n_out_full;
        r_out_last <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.hours       = r_out_tod.hours;
    assign o_out.minutes     = r_out_tod.minutes;
    assign o_out.seconds     = r_out_tod.seconds;
    assign o_out.code_digits = r_out_code;
    assign o_out.held        = r_out_held;
    assign o_out.log_full    = r_out_full;
    assign o_out.last        = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/kcl_code_table.sv =====
// ----------------------------------------------------------------------------
// kcl_code_table
// Code table memory with preset load, append and a sequential match scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_code_table import kcl_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_tbl_rsp o_rsp
);

    logic [15:0]   mem [TABLE_DEPTH];
    logic [15:0]   r_rd_data;

    logic          r_init;
    logic [2:0]    r_init_cnt;
    logic [CW-1:0] r_count;
    logic          r_scan;
    logic [CW-1:0] r_addr;
    logic          r_pend;
    logic          r_match;
    logic [15:0]   r_key;

    logic          full;
    logic          scan_end;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;

    assign full     = (r_count == CW'(TABLE_DEPTH));
    assign scan_end = r_scan && (r_addr == r_count) && !r_pend;

    always_comb begin
        we    = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = i_req.code;
        if (r_init) begin
            we    = 1'b1;
            waddr = AW'(r_init_cnt);
            wdata = PRESET_CODES[r_init_cnt];
        end else if (i_req.append && !full) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_cnt <= '0;
            r_count    <= CW'(PRESET_NUM);
            r_scan     <= 1'b0;
            r_addr     <= '0;
            r_pend     <= 1'b0;
            r_match    <= 1'b0;
        end else begin
            if (r_init) begin
                r_init_cnt <= r_init_cnt + 3'd1;
                if (r_init_cnt == 3'(PRESET_NUM - 1)) begin
                    r_init <= 1'b0;
                end
            end else if (i_req.append && !full) begin
                r_count <= r_count + CW'(1);
            end

            if (i_req.scan) begin
                r_scan  <= 1'b1;
                r_addr  <= '0;
                r_pend  <= 1'b0;
                r_match <= 1'b0;
            end else if (r_scan) begin
                // Read data of the previous address is registered in r_rd_data and compared here.
                if (r_pend && (r_rd_data == r_key)) begin
                    r_match <= 1'b1;
                end
                if (r_addr != r_count) begin
                    r_addr <= r_addr + CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (scan_end) begin
                    r_scan <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.scan) begin
            r_key <= i_req.code;
        end
    end

    assign o_rsp.busy  = r_init;
    assign o_rsp.full  = full;
    assign o_rsp.done  = scan_end;
    assign o_rsp.match = r_match;

endmodule

`default_nettype wire

// ===== rtl/core/kcl_event_log.sv =====
// ----------------------------------------------------------------------------
// kcl_event_log
// Saturating log memory of granted entries with a registered replay read.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_event_log import kcl_pkg::*; #(
    parameter int LOG_DEPTH = 32,
    localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
    localparam int LCW = $clog2(LOG_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_log_req       i_req,
    input  logic [LAW-1:0] i_rd_addr,
    output t_log_entry     o_rd_data,
    output logic           o_full,
    output logic [LCW-1:0] o_replay_n
);

    localparam int unsigned REPLAY_MAX =
        (LOG_DEPTH < MAX_RESULTS) ? LOG_DEPTH : MAX_RESULTS;

    t_log_entry     mem [LOG_DEPTH];
    t_log_entry     r_rd_data;
    logic [LCW-1:0] r_count;
    logic           full;

    assign full = (r_count == LCW'(LOG_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_req.append && !full) begin
            mem[r_count[LAW-1:0]] <= i_req.entry;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_req.append && !full) begin
            r_count <= r_count + LCW'(1);
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_full     = full;
    assign o_replay_n = (r_count > LCW'(REPLAY_MAX)) ? LCW'(REPLAY_MAX) : r_count;

endmodule

`default_nettype wire

// ===== test/keypad_code_lock_with_log_core_tb.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_with_log_core_tb
// Drives ticks and key presses into the code lock core and checks every
// result against a cycle-free model of the lock kept inside the bench. The
// tests cover directed cases, random key sequences, filling the entry log
// and the code table, and a run of back-to-back ticks. Both sides stall at
// random.
// ----------------------------------------------------------------------------
module keypad_code_lock_with_log_core_tb import kcl_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_SLOTS    = 32;
    localparam int LOG_SLOTS     = 32;
    localparam int DAY_SECONDS   = 86400;
    localparam int STUCK_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 60;
    localparam int TICK_RUN      = 12;
    localparam logic [3:0] KEY_UNUSED_MIN = 4'd12;
    localparam logic [3:0] KEY_UNUSED_MAX = 4'd15;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [15:0] code;
        logic        held;
        logic        log_full;
        logic        last;
    } lock_result_t;

    typedef struct packed {
        logic [16:0] stamp;
        logic [15:0] code;
    } log_rec_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kcl_in_if  in_if ();
    kcl_out_if out_if ();

    keypad_code_lock_with_log_core #(
        .TABLE_DEPTH(CODE_SLOTS),
        .LOG_DEPTH  (LOG_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model of the lock.
    logic [16:0] tod_q;
    int          digits_taken;
    logic [15:0] partial_code;
    bit          enrolling;
    logic [15:0] codes [CODE_SLOTS];
    int          codes_used;
    log_rec_t    entry_log [LOG_SLOTS];
    int          log_used;

    lock_result_t results_due [$];

    int  errors      = 0;
    int  items_sent  = 0;
    bit  idle_on     = 1'b1;
    bit  valid_up    = 1'b0;
    bit  ready_up    = 1'b0;
    int  stuck_cycles = 0;

    task automatic push_result(input logic [3:0] kind, input logic [16:0] stamp,
                               input logic [15:0] code, input logic full,
                               input logic last);
        lock_result_t r;
        r.kind     = kind;
        r.hours    = 5'(stamp / 17'd3600);
        r.minutes  = 6'((stamp / 17'd60) % 17'd60);
        r.seconds  = 6'(stamp % 17'd60);
        r.code     = code;
        r.held     = enrolling;
        r.log_full = full;
        r.last     = last;
        results_due.push_back(r);
    endtask

    task automatic predict_lock(input logic func, input logic [3:0] key);
        int          n;
        bit          hit;
        logic [15:0] code;
        if (func == FUNC_TICK) begin
            tod_q = (tod_q == 17'(DAY_SECONDS - 1)) ? 17'd0 : tod_q + 17'd1;
            push_result(KIND_TIME, tod_q, 16'h0, 1'b0, 1'b1);
        end else if (key == KEY_STAR) begin
            enrolling    = 1'b1;
            digits_taken = 0;
            partial_code = 16'h0;
            push_result(KIND_ENROL_START, tod_q, 16'h0, 1'b0, 1'b1);
        end else if (key == KEY_HASH) begin
            enrolling = 1'b0;
            n = (log_used < MAX_RESULTS) ? log_used : MAX_RESULTS;
            for (int i = 0; i < n; i++)
                push_result(KIND_LOG_ENTRY, entry_log[i].stamp, entry_log[i].code,
                            1'b0, i == n - 1);
            if (n == 0)
                push_result(KIND_LOG_EMPTY, tod_q, 16'h0, 1'b0, 1'b1);
        end else if (key <= KEY_DIGIT_MAX) begin
            partial_code = {partial_code[11:0], key};
            digits_taken++;
            if (digits_taken < 4) begin
                push_result(KIND_DIGIT, tod_q, partial_code, 1'b0, 1'b1);
            end else begin
                code         = partial_code;
                digits_taken = 0;
                partial_code = 16'h0;
                if (enrolling) begin
                    if (codes_used < CODE_SLOTS) begin
                        codes[codes_used] = code;
                        codes_used++;
                        enrolling = 1'b0;
                        push_result(KIND_ENROLLED, tod_q, code, 1'b0, 1'b1);
                    end else begin
                        // A refused code leaves enrol mode on.
                        push_result(KIND_TABLE_FULL, tod_q, code, 1'b0, 1'b1);
                    end
                end else begin
                    hit = 1'b0;
                    for (int i = 0; i < codes_used; i++)
                        if (codes[i] == code)
                            hit = 1'b1;
                    if (!hit) begin
                        push_result(KIND_DENIED, tod_q, code, 1'b0, 1'b1);
                    end else if (log_used < LOG_SLOTS) begin
                        entry_log[log_used] = '{stamp: tod_q, code: code};
                        log_used++;
                        push_result(KIND_GRANTED, tod_q, code, 1'b0, 1'b1);
                    end else begin
                        push_result(KIND_GRANTED, tod_q, code, 1'b1, 1'b1);
                    end
                end
            end
        end
    endtask

    task automatic send_item(input logic func, input logic [3:0] key);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            if (valid_up) begin
                in_if.valid <= 1'b0;
                valid_up = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func  <= func;
        in_if.key   <= key;
        valid_up = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        predict_lock(func, key);
        items_sent++;
    endtask

    task automatic send_code(input logic [15:0] code);
        for (int i = 3; i >= 0; i--)
            send_item(FUNC_KEY, code[4*i +: 4]);
    endtask

    function automatic logic [15:0] random_code();
        logic [15:0] c;
        for (int i = 0; i < 4; i++)
            c[4*i +: 4] = 4'($urandom_range(0, 9));
        return c;
    endfunction

    task automatic drain_results();
        if (valid_up) begin
            in_if.valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Brings the lock to the start of a fresh code outside enrol mode.
    task automatic align_to_code_start();
        if (enrolling)
            send_item(FUNC_KEY, KEY_HASH);
        while (digits_taken != 0)
            send_item(FUNC_KEY, 4'($urandom_range(0, 9)));
    endtask

    task automatic test_directed();
        send_item(FUNC_TICK, 4'h0);
        send_item(FUNC_KEY, KEY_HASH);         // nothing logged yet
        send_code(16'h1234);                   // preset code
        send_code(16'h9876);                   // not stored
        send_item(FUNC_KEY, 4'd1);
        send_item(FUNC_KEY, KEY_HASH);         // digit taken so far is kept
        send_item(FUNC_KEY, 4'd3);
        send_item(FUNC_KEY, 4'd8);
        send_item(FUNC_KEY, 4'd2);
        send_item(FUNC_KEY, KEY_STAR);
        send_code(16'h5009);
        for (int k = KEY_UNUSED_MIN; k <= KEY_UNUSED_MAX; k++)
            send_item(FUNC_KEY, 4'(k));
        send_item(FUNC_TICK, 4'hF);            // key field ignored on ticks
        send_item(FUNC_KEY, KEY_HASH);
    endtask

    task automatic test_random_mix(input int count);
        int target;
        int pick;
        int n;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_code(codes[$urandom_range(0, codes_used - 1)]);
            end else if (pick < 50) begin
                send_item(FUNC_KEY, KEY_STAR);
                send_code(random_code());
            end else if (pick < 65) begin
                send_code(random_code());
            end else if (pick < 75) begin
                send_item(FUNC_TICK, 4'($urandom_range(0, 15)));
            end else if (pick < 83) begin
                send_item(FUNC_KEY, KEY_HASH);
            end else if (pick < 88) begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(FUNC_KEY, 4'($urandom_range(0, 9)));
                send_item(FUNC_KEY, KEY_HASH);
            end else if (pick < 93) begin
                send_item(FUNC_KEY, 4'($urandom_range(KEY_UNUSED_MIN, KEY_UNUSED_MAX)));
            end else begin
                send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_log_full();
        // Let the lock go quiet before the log is filled.
        drain_results();
        align_to_code_start();
        while (log_used < LOG_SLOTS) begin
            if ($urandom_range(0, 3) == 0)
                send_item(FUNC_TICK, 4'h0);
            send_code(codes[$urandom_range(0, codes_used - 1)]);
        end
        repeat (2) send_code(codes[$urandom_range(0, codes_used - 1)]);
        send_item(FUNC_KEY, KEY_HASH);         // replay of a full log
    endtask

    task automatic test_table_full();
        while (codes_used < CODE_SLOTS) begin
            send_item(FUNC_KEY, KEY_STAR);
            send_code(random_code());
        end
        send_item(FUNC_KEY, KEY_STAR);
        send_code(random_code());
        send_code(random_code());              // still in enrol mode
        send_item(FUNC_KEY, KEY_HASH);
        send_code(codes[CODE_SLOTS - 1]);
    endtask

    task automatic test_tick_run();
        idle_on = 1'b0;
        repeat (TICK_RUN) send_item(FUNC_TICK, 4'($urandom_range(0, 15)));
        idle_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        lock_result_t want;
        if (results_due.size() == 0) begin
            $display("%0t: result of kind %0h with nothing expected, expected none",
                     $time, out_if.kind);
            errors++;
        end else begin
            want = results_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(out_if.kind));
            check_field("hours", 32'(want.hours), 32'(out_if.hours));
            check_field("minutes", 32'(want.minutes), 32'(out_if.minutes));
            check_field("seconds", 32'(want.seconds), 32'(out_if.seconds));
            check_field("code_digits", 32'(want.code), 32'(out_if.code_digits));
            check_field("held", 32'(want.held), 32'(out_if.held));
            check_field("log_full", 32'(want.log_full), 32'(out_if.log_full));
            check_field("last", 32'(want.last), 32'(out_if.last));
        end
    endtask

    // Result side: random stalls on ready, one check per transfer.
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 16) : 0;
            if (stall != 0) begin
                if (ready_up) begin
                    out_if.ready <= 1'b0;
                    ready_up = 1'b0;
                end
                repeat (stall) @(posedge i_clk);
            end
            if (!ready_up) begin
                out_if.ready <= 1'b1;
                ready_up = 1'b1;
            end
            do @(posedge i_clk); while (!out_if.valid);
            check_result();
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        tod_q        = 17'd0;
        digits_taken = 0;
        partial_code = 16'h0;
        enrolling    = 1'b0;
        for (int i = 0; i < CODE_SLOTS; i++)
            codes[i] = (i < PRESET_NUM) ? PRESET_CODES[i] : 16'h0;
        codes_used = PRESET_NUM;
        log_used   = 0;

        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.func  <= FUNC_TICK;
        in_if.key   <= 4'h0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(30);
        test_log_full();
        test_table_full();
        test_tick_run();
        test_random_mix(15);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kcl_pkg.sv
rtl/core/kcl_if.sv
rtl/core/kcl_code_table.sv
rtl/core/kcl_event_log.sv
rtl/core/keypad_code_lock_with_log_core.sv
test/keypad_code_lock_with_log_core_tb.sv
